>>> design/pfir_pkg.sv
package pfir_pkg;

    // default geometry of the filter bank
    localparam int NUM_TAPS_DEF = 4;
    localparam int NUM_CHAN_DEF = 256;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int IDX_W      = 10;
    localparam int OUT_W      = 36;
    localparam int CHAN_OUT_W = 8;
    localparam int PROD_W     = SAMPLE_W + COEF_W;

    // products summed per group in the first adder stage
    localparam int GRP_SIZE = 4;

    // item kinds
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_COEF = 1'b1;

    // control travelling alongside a sample through the weighting pipeline
    typedef struct packed {
        logic                  vld;
        logic [CHAN_OUT_W-1:0] chan;
        logic                  last;
    } t_s1_ctrl;

endpackage

>>> design/pfir_in_if.sv
interface pfir_in_if import pfir_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic        [IDX_W-1:0]    coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic                       stream_restart;

    modport source (
        output valid, mode, sample_re, sample_im, coef_index, coef_value, stream_restart,
        input  ready
    );

    modport sink (
        input  valid, mode, sample_re, sample_im, coef_index, coef_value, stream_restart,
        output ready
    );

endinterface

>>> design/pfir_out_if.sv
interface pfir_out_if import pfir_pkg::*; ();

    logic                         valid;
    logic                         ready;
    logic signed [OUT_W-1:0]      out_re;
    logic signed [OUT_W-1:0]      out_im;
    logic        [CHAN_OUT_W-1:0] out_channel;
    logic                         block_last;

    modport source (
        output valid, out_re, out_im, out_channel, block_last,
        input  ready
    );

    modport sink (
        input  valid, out_re, out_im, out_channel, block_last,
        output ready
    );

endinterface

>>> design/polyphase_fir_frontend_core.sv
// polyphase filter bank weighting stage
// a result passes through stage one, then the product, partial-sum and output registers
// throughput: one transaction per cycle unless the output stalls, set by one read
// of each per-tap memory bank per cycle and a fully pipelined multiply and adder tree
// reset: synchronous active low, clears the channel and block counters and the pipeline;
// history and coefficient memories are not cleared and must be written before use
module polyphase_fir_frontend_core import pfir_pkg::*; #(
    parameter int NUM_TAPS = NUM_TAPS_DEF,
    parameter int NUM_CHAN = NUM_CHAN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfir_in_if.sink   i_in,
    pfir_out_if.source o_out
);

    localparam int CH_W  = $clog2(NUM_CHAN);
    localparam int BLK_W = $clog2(NUM_TAPS);
    localparam int NHIST = NUM_TAPS - 1;
    localparam int HW    = 2 * SAMPLE_W;

    logic                       acc, acc_data, en1, adv;
    logic [CH_W-1:0]            r_chan, n_chan, cur_ch;
    logic [BLK_W-1:0]           r_blk, n_blk, cur_blk;
    logic [31:0]                idx32;

    logic                       r_v1, r_prod, r_last, r_byp;
    logic [CH_W-1:0]            r_ch;
    logic signed [SAMPLE_W-1:0] r_smp_re, r_smp_im;
    logic [HW-1:0]              r_wb   [NHIST];
    logic [HW-1:0]              hist_rd[NHIST];
    logic [HW-1:0]              hist_ef[NHIST];
    logic [HW-1:0]              hist_wr[NHIST];
    logic [COEF_W-1:0]          coef_rd[NUM_TAPS];
    logic                       coef_we[NUM_TAPS];
    logic [CH_W-1:0]            coef_wa[NUM_TAPS];

    logic signed [SAMPLE_W-1:0] tap_re [NUM_TAPS];
    logic signed [SAMPLE_W-1:0] tap_im [NUM_TAPS];
    logic signed [COEF_W-1:0]   tap_c  [NUM_TAPS];
    t_s1_ctrl                   s1;

    assign acc      = i_in.valid && i_in.ready;
    assign acc_data = acc && (i_in.mode == MODE_DATA);
    assign idx32    = 32'(i_in.coef_index);

    // stage one may be refilled unless it holds a result waiting on the multiplier stage
    assign s1.vld     = r_v1 && r_prod;
    assign s1.chan    = CHAN_OUT_W'(r_ch);
    assign s1.last    = r_last;
    assign en1        = !s1.vld || adv;
    assign i_in.ready = en1;

    // channel and block counting, restart clears before the sample is placed
    always_comb begin
        cur_ch  = i_in.stream_restart ? '0 : r_chan;
        cur_blk = i_in.stream_restart ? '0 : r_blk;
        n_chan  = r_chan;
        n_blk   = r_blk;
        if (acc_data) begin
            if (cur_ch == CH_W'(NUM_CHAN - 1)) begin
                n_chan = '0;
                n_blk  = (cur_blk == BLK_W'(NUM_TAPS - 1)) ? cur_blk : cur_blk + 1'b1;
            end else begin
                n_chan = cur_ch + 1'b1;
                n_blk  = cur_blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= '0;
            r_blk  <= '0;
            r_v1   <= 1'b0;
            r_byp  <= 1'b0;
        end else begin
            r_chan <= n_chan;
            r_blk  <= n_blk;
            if (en1) begin
                r_v1  <= acc_data;
                r_byp <= acc_data && r_v1 && (r_ch == cur_ch);
            end
        end
    end

    // stage one payload, plus the history just written for same-channel forwarding
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_prod   <= (cur_blk == BLK_W'(NUM_TAPS - 1));
            r_ch     <= cur_ch;
            r_last   <= (cur_ch == CH_W'(NUM_CHAN - 1));
            r_smp_re <= i_in.sample_re;
            r_smp_im <= i_in.sample_im;
            r_wb     <= hist_wr;
        end
    end

    // history banks: bank 0 holds the oldest stored block, bank NHIST-1 the newest
    for (genvar m = 0; m < NHIST; m++) begin : g_hist
        assign hist_ef[m] = r_byp ? r_wb[m] : hist_rd[m];
        if (m < NHIST - 1) begin : g_shift
            assign hist_wr[m] = hist_ef[m + 1];
        end else begin : g_newest
            assign hist_wr[m] = {r_smp_re, r_smp_im};
        end

        pfir_ram #(
            .WIDTH (HW),
            .DEPTH (NUM_CHAN)
        ) u_hist (
            .i_clk   (i_clk),
            .i_we    (en1 && r_v1),
            .i_waddr (r_ch),
            .i_wdata (hist_wr[m]),
            .i_re    (en1),
            .i_raddr (cur_ch),
            .o_rdata (hist_rd[m])
        );

        assign tap_re[m] = hist_ef[m][HW-1:SAMPLE_W];
        assign tap_im[m] = hist_ef[m][SAMPLE_W-1:0];
    end

    assign tap_re[NHIST] = r_smp_re;
    assign tap_im[NHIST] = r_smp_im;

    // coefficient banks, one per tap, address split into tap and channel
    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_coef
        localparam int LO = k * NUM_CHAN;

        assign coef_we[k] = acc && (i_in.mode == MODE_COEF) && (idx32 >= 32'(LO))
                            && (idx32 < 32'(LO + NUM_CHAN));
        assign coef_wa[k] = CH_W'(idx32 - 32'(LO));

        pfir_ram #(
            .WIDTH (COEF_W),
            .DEPTH (NUM_CHAN)
        ) u_coef (
            .i_clk   (i_clk),
            .i_we    (coef_we[k]),
            .i_waddr (coef_wa[k]),
            .i_wdata (i_in.coef_value),
            .i_re    (en1),
            .i_raddr (cur_ch),
            .o_rdata (coef_rd[k])
        );

        assign tap_c[k] = coef_rd[k];
    end

    // multiply and sum pipeline with the output register
    pfir_mac #(
        .NUM_TAPS (NUM_TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s1     (s1),
        .i_tap_re (tap_re),
        .i_tap_im (tap_im),
        .i_coef   (tap_c),
        .o_adv    (adv),
        .o_out    (o_out)
    );

    // forwarding only ever applies to a sample held in stage one
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_byp |-> r_v1)
        else $error("history forward flagged without a sample in stage one");

    // a coefficient write never enters the sample pipeline
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_in.mode == MODE_COEF)) |=> !r_v1)
        else $error("coefficient transaction entered stage one");

    // the first sample after a restart only fills history
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_data && i_in.stream_restart) |=> (r_v1 && !r_prod))
        else $error("result produced on the first sample of a stream");

    // block count saturates at the history depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blk <= BLK_W'(NUM_TAPS - 1))
        else $error("block counter passed its saturation value");

endmodule

>>> design/pfir_ram.sv
module pfir_ram import pfir_pkg::*; #(
    parameter int WIDTH = COEF_W,
    parameter int DEPTH = NUM_CHAN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while the reader stalls
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/pfir_mac.sv
module pfir_mac import pfir_pkg::*; #(
    parameter int NUM_TAPS = NUM_TAPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_s1_ctrl                   i_s1,
    input  logic signed [SAMPLE_W-1:0] i_tap_re [NUM_TAPS],
    input  logic signed [SAMPLE_W-1:0] i_tap_im [NUM_TAPS],
    input  logic signed [COEF_W-1:0]   i_coef   [NUM_TAPS],
    output logic                       o_adv,
    pfir_out_if.source                 o_out
);

    localparam int NGRP = (NUM_TAPS + GRP_SIZE - 1) / GRP_SIZE;

    t_s1_ctrl                r_c2, r_c3, r_c4;
    logic signed [PROD_W-1:0] r_p_re [NUM_TAPS];
    logic signed [PROD_W-1:0] r_p_im [NUM_TAPS];
    logic signed [OUT_W-1:0]  r_g_re [NGRP];
    logic signed [OUT_W-1:0]  r_g_im [NGRP];
    logic signed [OUT_W-1:0]  n_g_re [NGRP];
    logic signed [OUT_W-1:0]  n_g_im [NGRP];
    logic signed [OUT_W-1:0]  r_out_re, r_out_im;
    logic signed [OUT_W-1:0]  n_out_re, n_out_im;
    logic                     en2, en3, en4;

    // stage enables: a stage moves when its successor is empty or moving
    assign en4   = !r_c4.vld || o_out.ready;
    assign en3   = !r_c3.vld || en4;
    assign en2   = !r_c2.vld || en3;
    assign o_adv = en2;

    // control of each stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
        end else begin
            if (en2) begin
                r_c2 <= i_s1;
            end
            if (en3) begin
                r_c3 <= r_c2;
            end
            if (en4) begin
                r_c4 <= r_c3;
            end
        end
    end

    // tap products
    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int m = 0; m < NUM_TAPS; m++) begin
                r_p_re[m] <= PROD_W'(i_tap_re[m] * i_coef[m]);
                r_p_im[m] <= PROD_W'(i_tap_im[m] * i_coef[m]);
            end
        end
    end

    // partial sums over small groups of products
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_g_re[g] = '0;
            n_g_im[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (g * GRP_SIZE + j < NUM_TAPS) begin
                    n_g_re[g] = n_g_re[g] + OUT_W'(r_p_re[g * GRP_SIZE + j]);
                    n_g_im[g] = n_g_im[g] + OUT_W'(r_p_im[g * GRP_SIZE + j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_g_re <= n_g_re;
            r_g_im <= n_g_im;
        end
    end

    // final sum, wrapping at the output width
    always_comb begin
        n_out_re = '0;
        n_out_im = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_out_re = n_out_re + r_g_re[g];
            n_out_im = n_out_im + r_g_im[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out_re <= n_out_re;
            r_out_im <= n_out_im;
        end
    end

    // output transaction
    assign o_out.valid       = r_c4.vld;
    assign o_out.out_re      = r_out_re;
    assign o_out.out_im      = r_out_im;
    assign o_out.out_channel = r_c4.chan;
    assign o_out.block_last  = r_c4.last;

endmodule
